[rtl/uart_baud_register_calc_core_defines.svh]
// Assertion macros used by the checker of the baud register calculator.
// Depends on nothing. The user of a macro provides clk and rst in scope.
`ifndef UART_BAUD_REGISTER_CALC_CORE_DEFINES_SVH
`define UART_BAUD_REGISTER_CALC_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UBRC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ubrc check failed");

// Next-cycle implication, checked outside reset.
`define UBRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ubrc check failed");

`endif

[rtl/ubrc_pkg.sv]
// Shared types and constants for the USART baud register calculator.
// Used by every module of the block; depends on nothing.
package ubrc_pkg;

  localparam int DivSteps  = 35;  // quotient bits produced by the cell row
  localparam int RemWidth  = 32;
  localparam int ProdWidth = 28;  // 16 * (2^24 - 1) fits in 28 bits

  localparam logic [31:0] IntLimit  = 32'd8192;
  localparam int          FracShift = 13;

  localparam logic       ModeArith = 1'b0;
  localparam logic       ModeFrac  = 1'b1;
  localparam logic [1:0] Samp3x    = 2'd0;
  localparam logic [1:0] Samp8x    = 2'd1;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_RATE_HIGH = 2'd1,
    STAT_INT_OVER  = 2'd2,
    STAT_FRAC_3X   = 2'd3
  } status_t;

  // Data that travels along the divider cells with each request.
  typedef struct packed {
    logic [RemWidth-1:0]  rem;
    logic [DivSteps-1:0]  quo;   // dividend bits shift out, quotient bits shift in
    logic [RemWidth-1:0]  div;
    logic                 mode;
    logic                 force_zero;
    status_t              status;
  } work_t;

endpackage

[rtl/ubrc_front.sv]
// Entry stage: oversampled rate product, early status checks, divider setup.
// Depends on ubrc_pkg.
module ubrc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                in_valid,
  input  logic                mode,
  input  logic [1:0]          sampling_code,
  input  logic [23:0]         bit_rate,
  input  logic [31:0]         ref_clock,
  output logic                work_valid,
  output ubrc_pkg::work_t     work
);

  logic [ubrc_pkg::ProdWidth-1:0] prod;
  ubrc_pkg::work_t                work_next;

  always_comb begin
    case (sampling_code)
      ubrc_pkg::Samp3x: prod = {3'b0, bit_rate, 1'b0} + {4'b0, bit_rate};
      ubrc_pkg::Samp8x: prod = {1'b0, bit_rate, 3'b0};
      default:          prod = {bit_rate, 4'b0};
    endcase
  end

  always_comb begin
    work_next.mode       = mode;
    work_next.force_zero = (mode == ubrc_pkg::ModeArith) && (prod == '0);

    if (mode == ubrc_pkg::ModeFrac && sampling_code == ubrc_pkg::Samp3x) begin
      work_next.status = ubrc_pkg::STAT_FRAC_3X;
    end else if ({4'b0, prod} > ref_clock) begin
      work_next.status = ubrc_pkg::STAT_RATE_HIGH;
    end else if (mode == ubrc_pkg::ModeFrac && prod == '0) begin
      work_next.status = ubrc_pkg::STAT_INT_OVER;
    end else begin
      work_next.status = ubrc_pkg::STAT_OK;
    end

    // Arithmetic mode divides prod * 2^32 by the clock; the top dividend bits
    // preload the remainder. Fractional mode divides clock * 8 by prod.
    if (mode == ubrc_pkg::ModeArith) begin
      work_next.rem = {7'b0, prod[ubrc_pkg::ProdWidth-1:3]};
      work_next.quo = {prod[2:0], 32'b0};
      work_next.div = ref_clock;
    end else begin
      work_next.rem = '0;
      work_next.quo = {ref_clock, 3'b0};
      work_next.div = {4'b0, prod};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (advance) begin
      work_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      work <= work_next;
    end
  end

endmodule

[rtl/ubrc_div_cell.sv]
// One restoring division cell: produces one quotient bit per request.
// Depends on ubrc_pkg.
module ubrc_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic            prev_valid,
  input  ubrc_pkg::work_t prev_work,
  output logic            work_valid,
  output ubrc_pkg::work_t work
);

  logic [ubrc_pkg::RemWidth:0] trial;
  logic [ubrc_pkg::RemWidth:0] diff;
  logic                        take;
  ubrc_pkg::work_t             work_next;

  always_comb begin
    trial = {prev_work.rem, prev_work.quo[ubrc_pkg::DivSteps-1]};
    diff  = trial - {1'b0, prev_work.div};
    take  = trial >= {1'b0, prev_work.div};

    work_next     = prev_work;
    work_next.rem = take ? diff[ubrc_pkg::RemWidth-1:0] : trial[ubrc_pkg::RemWidth-1:0];
    work_next.quo = {prev_work.quo[ubrc_pkg::DivSteps-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (advance) begin
      work_valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      work <= work_next;
    end
  end

endmodule

[rtl/ubrc_back.sv]
// Result stage: turns the quotient into the baud register value and status.
// Depends on ubrc_pkg.
module ubrc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic            last_valid,
  input  ubrc_pkg::work_t last_work,
  output logic            out_valid,
  output logic [15:0]     baud_value,
  output logic [1:0]      status
);

  logic [32:0]       scale;
  logic [31:0]       int_part;
  logic [2:0]        eighths;
  logic [15:0]       baud_next;
  ubrc_pkg::status_t status_next;

  always_comb begin
    scale    = 33'h1_0000_0000 - last_work.quo[32:0];
    int_part = last_work.quo[ubrc_pkg::DivSteps-1:3];
    eighths  = last_work.quo[2:0];

    status_next = last_work.status;
    baud_next   = '0;
    if (last_work.status == ubrc_pkg::STAT_OK) begin
      if (last_work.mode == ubrc_pkg::ModeArith) begin
        // Taking bits 31:16 drops the 2^32 case to zero, as the register does.
        baud_next = last_work.force_zero ? 16'd0 : scale[31:16];
      end else if (int_part > ubrc_pkg::IntLimit) begin
        status_next = ubrc_pkg::STAT_INT_OVER;
      end else begin
        baud_next = {eighths, 13'b0} | {2'b0, int_part[ubrc_pkg::FracShift:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      baud_value <= baud_next;
      status     <= status_next;
    end
  end

endmodule

[rtl/uart_baud_register_calc_core.sv]
// Top level of the USART baud register calculator.
// Depends on ubrc_pkg, ubrc_front, ubrc_div_cell and ubrc_back.
//
// Usage:
//   A request (mode, sampling_code, bit_rate, ref_clock) is taken at a rising
//   edge where in_valid is high and in_stall is low. One result (baud_value,
//   status) is offered on out_valid and taken when out_stall is low.
//   The request passes an entry stage, a row of 35 division cells that each
//   settle one quotient bit, and a result register.
//   Throughput is one request per cycle while in_stall is low; every
//   stage is a register, so a new request enters while older ones are still in the row.
//   When the receiver stalls a valid result, the whole row holds and
//   in_stall rises in the same cycle; nothing is dropped or repeated.
//   Reset clears all valid flags, so no result is offered after reset.
//   baud_value is zero whenever status reports an error.
module uart_baud_register_calc_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [1:0]  sampling_code,
  input  logic [23:0] bit_rate,
  input  logic [31:0] ref_clock,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] baud_value,
  output logic [1:0]  status
);

  logic            advance;
  logic            stage_valid [0:ubrc_pkg::DivSteps];
  ubrc_pkg::work_t stage_work  [0:ubrc_pkg::DivSteps];

  // The row moves whenever the result register is empty or being drained.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  ubrc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .in_valid      (in_valid),
    .mode          (mode),
    .sampling_code (sampling_code),
    .bit_rate      (bit_rate),
    .ref_clock     (ref_clock),
    .work_valid    (stage_valid[0]),
    .work          (stage_work[0])
  );

  for (genvar i = 0; i < ubrc_pkg::DivSteps; i++) begin : g_cell
    ubrc_div_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .prev_valid (stage_valid[i]),
      .prev_work  (stage_work[i]),
      .work_valid (stage_valid[i+1]),
      .work       (stage_work[i+1])
    );
  end

  ubrc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .last_valid (stage_valid[ubrc_pkg::DivSteps]),
    .last_work  (stage_work[ubrc_pkg::DivSteps]),
    .out_valid  (out_valid),
    .baud_value (baud_value),
    .status     (status)
  );

endmodule

[rtl/ubrc_checker.sv]
// Port-level checks for the baud register calculator, bound to the top level.
// Depends on ubrc_pkg and uart_baud_register_calc_core_defines.svh.
`include "uart_baud_register_calc_core_defines.svh"

module ubrc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] baud_value,
  input logic [1:0]  status
);

  // An error result never carries a register value.
  `UBRC_ASSERT_IMPL(a_err_zero, out_valid && (status != ubrc_pkg::STAT_OK), baud_value == 16'd0)

  // Requests are refused only while a finished result waits.
  `UBRC_ASSERT_IMPL(a_stall_cause, !(out_valid && out_stall), !in_stall)

  `UBRC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  `UBRC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(baud_value) && $stable(status))

endmodule

bind uart_baud_register_calc_core ubrc_checker u_ubrc_checker (.*);
